// ===== src/ftp_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Five-tuple header parser package
// Shared constants, codes and record types for the header parser.
// ----------------------------------------------------------------------------
package ftp_pkg;

   localparam int unsigned FTP_OFFSET_BITS = 16;

   localparam logic [7:0]  PROTO_TCP = 8'd6;
   localparam logic [7:0]  PROTO_UDP = 8'd17;
   localparam logic [15:0] FAM_V4    = 16'd2;
   localparam logic [15:0] FAM_V6    = 16'd10;

   localparam int unsigned V6_NEXT_POS    = 6;
   localparam int unsigned V4_PROTO_POS   = 9;
   localparam int unsigned SRC_ADDR_POS   = 8;
   localparam int unsigned DST_ADDR_POS   = 24;
   localparam int unsigned ADDR_WORD_LEN  = 8;
   localparam int unsigned V6_SPORT_POS   = 40;
   localparam int unsigned V6_DPORT_POS   = 42;
   localparam int unsigned PORT_LEN       = 2;
   localparam int unsigned PORT_BYTES     = 4;
   localparam int unsigned V4_HDR_BYTES   = 20;
   localparam int unsigned V6_HDR_BYTES   = 40;
   localparam int unsigned V6_MIN_BYTES   = 44;
   localparam int unsigned TCP_HDR_BYTES  = 20;
   localparam int unsigned UDP_HDR_BYTES  = 8;

   localparam int unsigned QUEUE_DEPTH      = 2;
   localparam int unsigned QUEUE_PTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int unsigned QUEUE_COUNT_BITS = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      KIND_V4    = 2'd0,
      KIND_V6    = 2'd1,
      KIND_OTHER = 2'd2
   } ftp_kind_type;

   typedef struct packed {
      logic        inbound;
      logic [15:0] family;
      logic [7:0]  frame_class;
      logic [31:0] packet_len;
      logic [31:0] ifindex;
   } ftp_meta_type;

   typedef struct packed {
      ftp_kind_type    kind;
      logic            ports_ok;
      logic [7:0]      proto;
      logic [7:0]      v6_next;
      logic [1:0][63:0] src_addr;
      logic [1:0][63:0] dst_addr;
      logic [15:0]     src_port;
      logic [15:0]     dst_port;
      logic [15:0]     v6_src_port;
      logic [15:0]     v6_dst_port;
      ftp_meta_type    meta;
   } ftp_event_type;

   typedef struct packed {
      logic        direction_in;
      logic [7:0]  protocol;
      logic [63:0] src_addr_hi;
      logic [63:0] src_addr_lo;
      logic [63:0] dst_addr_hi;
      logic [63:0] dst_addr_lo;
      logic [15:0] src_port;
      logic [15:0] dst_port;
      logic [15:0] family_out;
      logic [7:0]  pkt_type_out;
      logic [31:0] byte_count;
      logic [31:0] ifindex_out;
   } ftp_rsp_type;

endpackage
`default_nettype wire

// ===== src/ftp_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Five-tuple header parser channels
// Valid/ready channels for packet bytes in and flow events out.
// ----------------------------------------------------------------------------
interface ftp_req_if;
   logic        valid;
   logic        ready;
   logic [7:0]  data_byte;
   logic        last_byte;
   logic [15:0] family;
   logic        inbound;
   logic [7:0]  frame_class;
   logic [31:0] packet_len;
   logic [31:0] ifindex;

   modport source (
      output valid, data_byte, last_byte, family, inbound, frame_class, packet_len, ifindex,
      input  ready
   );
   modport sink (
      input  valid, data_byte, last_byte, family, inbound, frame_class, packet_len, ifindex,
      output ready
   );
endinterface

interface ftp_rsp_if;
   logic        valid;
   logic        ready;
   logic        direction_in;
   logic [7:0]  protocol;
   logic [63:0] src_addr_hi;
   logic [63:0] src_addr_lo;
   logic [63:0] dst_addr_hi;
   logic [63:0] dst_addr_lo;
   logic [15:0] src_port;
   logic [15:0] dst_port;
   logic [15:0] family_out;
   logic [7:0]  pkt_type_out;
   logic [31:0] byte_count;
   logic [31:0] ifindex_out;

   modport source (
      output valid, direction_in, protocol, src_addr_hi, src_addr_lo, dst_addr_hi,
             dst_addr_lo, src_port, dst_port, family_out, pkt_type_out, byte_count,
             ifindex_out,
      input  ready
   );
   modport sink (
      input  valid, direction_in, protocol, src_addr_hi, src_addr_lo, dst_addr_hi,
             dst_addr_lo, src_port, dst_port, family_out, pkt_type_out, byte_count,
             ifindex_out,
      output ready
   );
endinterface
`default_nettype wire

// ===== src/ftp_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Five-tuple header parser front end
// Tracks byte position, captures header fields and classifies the packet
// on its last beat, pushing one event record into the queue if the packet is long enough.
// ----------------------------------------------------------------------------
module ftp_front import ftp_pkg::*; #(
   parameter int unsigned OFFSET_BITS = FTP_OFFSET_BITS
) (
   input  logic          clock,
   input  logic          reset,
   ftp_req_if.sink       req_chan,
   output logic          push_valid,
   input  logic          push_ready,
   output ftp_event_type push_event
);

   localparam int unsigned CW = OFFSET_BITS + 1;

   logic [OFFSET_BITS-1:0] offset_ff, offset_in;
   logic [3:0]             hlw_ff, hlw_in, hlw_cur;
   logic [7:0]             proto_ff, proto_in, cap_proto;
   logic [7:0]             v6_next_ff, v6_next_in, cap_v6_next;
   logic [1:0][63:0]       src_addr_ff, src_addr_in, cap_src_addr;
   logic [1:0][63:0]       dst_addr_ff, dst_addr_in, cap_dst_addr;
   logic [15:0]            sport_ff, sport_in, cap_sport;
   logic [15:0]            dport_ff, dport_in, cap_dport;
   logic [15:0]            v6_sport_ff, v6_sport_in, cap_v6_sport;
   logic [15:0]            v6_dport_ff, v6_dport_in, cap_v6_dport;

   logic          accept;
   logic          at_max;
   logic [7:0]    b;
   logic [CW-1:0] pos, avail, t4_ext;
   ftp_kind_type  kind;
   logic          emit, ports_ok;

   function automatic logic ports_fit(input logic [7:0] proto, input logic [CW-1:0] have,
                                      input logic [CW-1:0] toff);
      logic fit;
      fit = 1'b0;
      if (proto == PROTO_TCP) begin
         fit = (have >= toff + CW'(TCP_HDR_BYTES));
      end else if (proto == PROTO_UDP) begin
         fit = (have >= toff + CW'(UDP_HDR_BYTES));
      end
      return fit;
   endfunction

   assign req_chan.ready = push_ready;
   assign accept = req_chan.valid & push_ready;
   assign b      = req_chan.data_byte;
   assign at_max = (offset_ff == '1);
   assign pos    = CW'(offset_ff);
   assign avail  = pos + CW'(1);
   assign hlw_cur = (offset_ff == '0) ? b[3:0] : hlw_ff;
   assign t4_ext = CW'({hlw_cur, 2'b00});

   always_comb begin
      cap_proto    = proto_ff;
      cap_v6_next  = v6_next_ff;
      cap_src_addr = src_addr_ff;
      cap_dst_addr = dst_addr_ff;
      cap_sport    = sport_ff;
      cap_dport    = dport_ff;
      cap_v6_sport = v6_sport_ff;
      cap_v6_dport = v6_dport_ff;
      if (!at_max) begin
         if (pos == CW'(V6_NEXT_POS)) begin
            cap_v6_next = b;
         end
         if (pos == CW'(V4_PROTO_POS)) begin
            cap_proto = b;
         end
         if (pos >= CW'(SRC_ADDR_POS) && pos < CW'(SRC_ADDR_POS + ADDR_WORD_LEN)) begin
            cap_src_addr[0] = {src_addr_ff[0][55:0], b};
         end
         if (pos >= CW'(SRC_ADDR_POS + ADDR_WORD_LEN) &&
             pos < CW'(SRC_ADDR_POS + 2 * ADDR_WORD_LEN)) begin
            cap_src_addr[1] = {src_addr_ff[1][55:0], b};
         end
         if (pos >= CW'(DST_ADDR_POS) && pos < CW'(DST_ADDR_POS + ADDR_WORD_LEN)) begin
            cap_dst_addr[0] = {dst_addr_ff[0][55:0], b};
         end
         if (pos >= CW'(DST_ADDR_POS + ADDR_WORD_LEN) &&
             pos < CW'(DST_ADDR_POS + 2 * ADDR_WORD_LEN)) begin
            cap_dst_addr[1] = {dst_addr_ff[1][55:0], b};
         end
         if (pos >= CW'(V6_SPORT_POS) && pos < CW'(V6_SPORT_POS + PORT_LEN)) begin
            cap_v6_sport = {v6_sport_ff[7:0], b};
         end
         if (pos >= CW'(V6_DPORT_POS) && pos < CW'(V6_DPORT_POS + PORT_LEN)) begin
            cap_v6_dport = {v6_dport_ff[7:0], b};
         end
         if (pos >= t4_ext && pos < t4_ext + CW'(PORT_LEN)) begin
            cap_sport = {sport_ff[7:0], b};
         end
         if (pos >= t4_ext + CW'(PORT_LEN) && pos < t4_ext + CW'(PORT_BYTES)) begin
            cap_dport = {dport_ff[7:0], b};
         end
      end
   end

   always_comb begin
      priority if (req_chan.family == FAM_V4) begin
         kind     = KIND_V4;
         emit     = (avail >= CW'(V4_HDR_BYTES)) && (avail >= t4_ext + CW'(PORT_BYTES));
         ports_ok = ports_fit(cap_proto, avail, t4_ext);
      end else if (req_chan.family == FAM_V6) begin
         kind     = KIND_V6;
         emit     = (avail >= CW'(V6_MIN_BYTES));
         ports_ok = ports_fit(cap_v6_next, avail, CW'(V6_HDR_BYTES));
      end else begin
         kind     = KIND_OTHER;
         emit     = 1'b1;
         ports_ok = 1'b0;
      end
   end

   assign push_valid = accept & req_chan.last_byte & emit;

   always_comb begin
      push_event                  = '0;
      push_event.kind             = kind;
      push_event.ports_ok         = ports_ok;
      push_event.proto            = cap_proto;
      push_event.v6_next          = cap_v6_next;
      push_event.src_addr         = cap_src_addr;
      push_event.dst_addr         = cap_dst_addr;
      push_event.src_port         = cap_sport;
      push_event.dst_port         = cap_dport;
      push_event.v6_src_port      = cap_v6_sport;
      push_event.v6_dst_port      = cap_v6_dport;
      push_event.meta.inbound     = req_chan.inbound;
      push_event.meta.family      = req_chan.family;
      push_event.meta.frame_class = req_chan.frame_class;
      push_event.meta.packet_len  = req_chan.packet_len;
      push_event.meta.ifindex     = req_chan.ifindex;
   end

   always_comb begin
      offset_in   = offset_ff;
      hlw_in      = hlw_ff;
      proto_in    = proto_ff;
      v6_next_in  = v6_next_ff;
      src_addr_in = src_addr_ff;
      dst_addr_in = dst_addr_ff;
      sport_in    = sport_ff;
      dport_in    = dport_ff;
      v6_sport_in = v6_sport_ff;
      v6_dport_in = v6_dport_ff;
      if (accept) begin
         if (req_chan.last_byte) begin
            offset_in   = '0;
            hlw_in      = '0;
            proto_in    = '0;
            v6_next_in  = '0;
            src_addr_in = '0;
            dst_addr_in = '0;
            sport_in    = '0;
            dport_in    = '0;
            v6_sport_in = '0;
            v6_dport_in = '0;
         end else begin
            if (!at_max) begin
               offset_in = offset_ff + OFFSET_BITS'(1);
            end
            hlw_in      = hlw_cur;
            proto_in    = cap_proto;
            v6_next_in  = cap_v6_next;
            src_addr_in = cap_src_addr;
            dst_addr_in = cap_dst_addr;
            sport_in    = cap_sport;
            dport_in    = cap_dport;
            v6_sport_in = cap_v6_sport;
            v6_dport_in = cap_v6_dport;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff   <= '0;
         hlw_ff      <= '0;
         proto_ff    <= '0;
         v6_next_ff  <= '0;
         src_addr_ff <= '0;
         dst_addr_ff <= '0;
         sport_ff    <= '0;
         dport_ff    <= '0;
         v6_sport_ff <= '0;
         v6_dport_ff <= '0;
      end else begin
         offset_ff   <= offset_in;
         hlw_ff      <= hlw_in;
         proto_ff    <= proto_in;
         v6_next_ff  <= v6_next_in;
         src_addr_ff <= src_addr_in;
         dst_addr_ff <= dst_addr_in;
         sport_ff    <= sport_in;
         dport_ff    <= dport_in;
         v6_sport_ff <= v6_sport_in;
         v6_dport_ff <= v6_dport_in;
      end
   end

endmodule
`default_nettype wire

// ===== src/ftp_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Five-tuple header parser event queue
// Short FIFO of event records between the front end and the back end.
// ----------------------------------------------------------------------------
module ftp_queue import ftp_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          push_valid,
   output logic          push_ready,
   input  ftp_event_type push_event,
   output logic          pop_valid,
   input  logic          pop_ready,
   output ftp_event_type pop_event
);

   ftp_event_type               entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_COUNT_BITS-1:0] count_ff, count_in;
   logic                        do_push, do_pop;

   assign push_ready = (count_ff != QUEUE_COUNT_BITS'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_event  = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid & push_ready;
   assign do_pop     = pop_valid & pop_ready;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + QUEUE_PTR_BITS'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + QUEUE_PTR_BITS'(1) : rd_ptr_ff;
      unique case ({do_push, do_pop})
         2'b10:   count_in = count_ff + QUEUE_COUNT_BITS'(1);
         2'b01:   count_in = count_ff - QUEUE_COUNT_BITS'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_event;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule
`default_nettype wire

// ===== src/ftp_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Five-tuple header parser back end
// Formats queued event records by address family into the output register.
// ----------------------------------------------------------------------------
module ftp_back import ftp_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          pop_valid,
   output logic          pop_ready,
   input  ftp_event_type pop_event,
   ftp_rsp_if.source     rsp_chan
);

   logic        valid_ff, valid_in;
   ftp_rsp_type data_ff, data_in, formatted;
   logic        load;

   assign pop_ready = ~valid_ff | rsp_chan.ready;
   assign load      = pop_valid & pop_ready;

   always_comb begin
      formatted              = '0;
      formatted.direction_in = pop_event.meta.inbound;
      formatted.family_out   = pop_event.meta.family;
      formatted.pkt_type_out = pop_event.meta.frame_class;
      formatted.byte_count   = pop_event.meta.packet_len;
      formatted.ifindex_out  = pop_event.meta.ifindex;
      unique case (pop_event.kind)
         KIND_V4: begin
            formatted.protocol    = pop_event.proto;
            formatted.src_addr_lo = {32'd0, pop_event.src_addr[0][31:0]};
            formatted.dst_addr_lo = {32'd0, pop_event.src_addr[1][63:32]};
            if (pop_event.ports_ok) begin
               formatted.src_port = pop_event.src_port;
               formatted.dst_port = pop_event.dst_port;
            end
         end
         KIND_V6: begin
            formatted.protocol    = pop_event.v6_next;
            formatted.src_addr_hi = pop_event.src_addr[0];
            formatted.src_addr_lo = pop_event.src_addr[1];
            formatted.dst_addr_hi = pop_event.dst_addr[0];
            formatted.dst_addr_lo = pop_event.dst_addr[1];
            if (pop_event.ports_ok) begin
               formatted.src_port = pop_event.v6_src_port;
               formatted.dst_port = pop_event.v6_dst_port;
            end
         end
         default: begin
            formatted.protocol = '0;
         end
      endcase
   end

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (load) begin
         valid_in = 1'b1;
         data_in  = formatted;
      end else if (rsp_chan.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign rsp_chan.valid        = valid_ff;
   assign rsp_chan.direction_in = data_ff.direction_in;
   assign rsp_chan.protocol     = data_ff.protocol;
   assign rsp_chan.src_addr_hi  = data_ff.src_addr_hi;
   assign rsp_chan.src_addr_lo  = data_ff.src_addr_lo;
   assign rsp_chan.dst_addr_hi  = data_ff.dst_addr_hi;
   assign rsp_chan.dst_addr_lo  = data_ff.dst_addr_lo;
   assign rsp_chan.src_port     = data_ff.src_port;
   assign rsp_chan.dst_port     = data_ff.dst_port;
   assign rsp_chan.family_out   = data_ff.family_out;
   assign rsp_chan.pkt_type_out = data_ff.pkt_type_out;
   assign rsp_chan.byte_count   = data_ff.byte_count;
   assign rsp_chan.ifindex_out  = data_ff.ifindex_out;

endmodule
`default_nettype wire

// ===== src/ip_five_tuple_header_parser_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Five-tuple header parser
// An event enters a queue entry on its packet's last beat, then the output register.
// Throughput: one packet byte per cycle while the queue has room; the byte-position tracker,
// two-entry event queue and output register sustain one event a cycle while rsp_chan is ready.
// Reset: synchronous, clears byte position, captures, queue and output valid.
// ----------------------------------------------------------------------------
module ip_five_tuple_header_parser_unit import ftp_pkg::*; #(
   parameter int unsigned OFFSET_BITS = FTP_OFFSET_BITS
) (
   input  logic      clock,
   input  logic      reset,
   ftp_req_if.sink   req_chan,
   ftp_rsp_if.source rsp_chan
);

   logic          push_valid, push_ready;
   ftp_event_type push_event;
   logic          pop_valid, pop_ready;
   ftp_event_type pop_event;

   ftp_front #(
      .OFFSET_BITS (OFFSET_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_event (push_event)
   );

   ftp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_event (push_event),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_event  (pop_event)
   );

   ftp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_event (pop_event),
      .rsp_chan  (rsp_chan)
   );

endmodule
`default_nettype wire
